// ----- sv/slbm_pkg.sv -----
package slbm_pkg;

    localparam int OPCODE_W   = 2;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int REG_W      = 5;
    localparam int COUNT_W    = 3;
    localparam int GUARD_W    = 2;
    localparam int PRG_BANK_W = 4;
    localparam int CHR_BANK_W = 5;
    localparam int MIRROR_W   = 2;

    localparam logic [REG_W-1:0]   CONTROL_RESET  = 5'h0C;
    localparam logic [REG_W-1:0]   CONTROL_FORCE  = 5'h0C;
    localparam logic [COUNT_W-1:0] BITS_PER_REG   = 3'd5;
    localparam logic [GUARD_W-1:0] GUARD_RELOAD   = 2'd2;

    // Data bit 7 of a port write clears the shifter.
    localparam int RESET_BIT = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK       = 2'd0,
        OP_PORT_WRITE = 2'd1,
        OP_WRAM_READ  = 2'd2,
        OP_WRAM_WRITE = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        SEL_CONTROL    = 2'd0,
        SEL_CHR_FIRST  = 2'd1,
        SEL_CHR_SECOND = 2'd2,
        SEL_PRG        = 2'd3
    } t_reg_sel;

    typedef struct packed {
        logic [REG_W-1:0] control;
        logic [REG_W-1:0] chr_first;
        logic [REG_W-1:0] chr_second;
        logic [REG_W-1:0] prg;
        logic             variant_a;
    } t_bank_regs;

    typedef struct packed {
        logic [PRG_BANK_W-1:0] prg_bank_low;
        logic [PRG_BANK_W-1:0] prg_bank_high;
        logic [CHR_BANK_W-1:0] chr_bank_low;
        logic [CHR_BANK_W-1:0] chr_bank_high;
        logic [MIRROR_W-1:0]   mirroring;
        logic                  wram_enabled;
        logic [DATA_W-1:0]     open_bus_data;
    } t_result;

endpackage

// ----- sv/slbm_in_if.sv -----
interface slbm_in_if;
    import slbm_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [ADDR_W-1:0]   address;
    logic [DATA_W-1:0]   write_data;

    modport source (output valid, opcode, address, write_data, input ready);
    modport sink (input valid, opcode, address, write_data, output ready);
endinterface

// ----- sv/slbm_out_if.sv -----
interface slbm_out_if;
    import slbm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PRG_BANK_W-1:0] prg_bank_low;
    logic [PRG_BANK_W-1:0] prg_bank_high;
    logic [CHR_BANK_W-1:0] chr_bank_low;
    logic [CHR_BANK_W-1:0] chr_bank_high;
    logic [MIRROR_W-1:0]   mirroring;
    logic                  wram_enabled;
    logic [DATA_W-1:0]     open_bus_data;

    modport source (
        output valid, prg_bank_low, prg_bank_high, chr_bank_low, chr_bank_high,
               mirroring, wram_enabled, open_bus_data,
        input  ready
    );
    modport sink (
        input  valid, prg_bank_low, prg_bank_high, chr_bank_low, chr_bank_high,
               mirroring, wram_enabled, open_bus_data,
        output ready
    );
endinterface

// ----- sv/slbm_cfg_if.sv -----
interface slbm_cfg_if;
    logic valid;
    logic ready;
    logic chip_is_variant_a;

    modport source (output valid, chip_is_variant_a, input ready);
    modport sink (input valid, chip_is_variant_a, output ready);
endinterface

// ----- sv/slbm_regs.sv -----
module slbm_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  slbm_pkg::t_opcode             i_opcode,
    input  logic [slbm_pkg::ADDR_W-1:0]   i_address,
    input  logic [slbm_pkg::DATA_W-1:0]   i_write_data,
    input  logic                          i_cfg_write,
    input  logic                          i_cfg_variant_a,
    output slbm_pkg::t_bank_regs          o_regs_next
);
    import slbm_pkg::*;

    t_bank_regs          r_regs, n_regs;
    logic [REG_W-1:0]    r_shift, n_shift;
    logic [COUNT_W-1:0]  r_bit_count, n_bit_count;
    logic [GUARD_W-1:0]  r_write_guard, n_write_guard;

    logic [REG_W-1:0]    shift_in;
    logic [COUNT_W-1:0]  count_inc;
    t_reg_sel            reg_sel;

    assign shift_in  = r_shift | (REG_W'(i_write_data[0]) << r_bit_count);
    assign count_inc = r_bit_count + 3'd1;
    assign reg_sel   = t_reg_sel'(i_address[14:13]);

    always_comb begin
        n_regs        = r_regs;
        n_shift       = r_shift;
        n_bit_count   = r_bit_count;
        n_write_guard = r_write_guard;
        if (i_cfg_write) begin
            n_regs.variant_a = i_cfg_variant_a;
        end
        if (i_accept) begin
            case (i_opcode)
                OP_TICK: begin
                    if (r_write_guard != '0) begin
                        n_write_guard = r_write_guard - 2'd1;
                    end
                end
                OP_PORT_WRITE: begin
                    if (i_write_data[RESET_BIT]) begin
                        n_regs.control = r_regs.control | CONTROL_FORCE;
                        n_shift        = '0;
                        n_bit_count    = '0;
                    end else if (r_write_guard == '0) begin
                        n_shift     = shift_in;
                        n_bit_count = count_inc;
                        // The fifth bit completes the value and commits it.
                        if (count_inc >= BITS_PER_REG) begin
                            case (reg_sel)
                                SEL_CONTROL:    n_regs.control    = shift_in;
                                SEL_CHR_FIRST:  n_regs.chr_first  = shift_in;
                                SEL_CHR_SECOND: n_regs.chr_second = shift_in;
                                default:        n_regs.prg        = shift_in;
                            endcase
                            n_shift     = '0;
                            n_bit_count = '0;
                        end
                    end
                    n_write_guard = GUARD_RELOAD;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.control    <= CONTROL_RESET;
            r_regs.chr_first  <= '0;
            r_regs.chr_second <= '0;
            r_regs.prg        <= '0;
            r_regs.variant_a  <= 1'b0;
            r_shift           <= '0;
            r_bit_count       <= '0;
            r_write_guard     <= '0;
        end else begin
            r_regs        <= n_regs;
            r_shift       <= n_shift;
            r_bit_count   <= n_bit_count;
            r_write_guard <= n_write_guard;
        end
    end

    assign o_regs_next = n_regs;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count < BITS_PER_REG)
        else $error("serial bit count passed a full register");

    a_guard_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_opcode == OP_PORT_WRITE |=> r_write_guard == GUARD_RELOAD)
        else $error("write guard not reloaded after a port write");

    a_reset_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_opcode == OP_PORT_WRITE && i_write_data[RESET_BIT]
        |=> r_regs.control[3:2] == 2'b11 && r_bit_count == '0 && r_shift == '0)
        else $error("reset write did not clear the shifter and force the mode bits");

    a_wram_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_cfg_write
        && (i_opcode == OP_WRAM_READ || i_opcode == OP_WRAM_WRITE)
        |=> $stable(r_regs) && $stable(r_shift) && $stable(r_bit_count)
            && $stable(r_write_guard))
        else $error("work RAM access changed mapper state");

endmodule

// ----- sv/slbm_decode.sv -----
module slbm_decode (
    input  slbm_pkg::t_bank_regs          i_regs,
    input  logic [slbm_pkg::ADDR_W-1:0]   i_address,
    output slbm_pkg::t_result             o_result
);
    import slbm_pkg::*;

    logic [REG_W-1:0] prg_raw_low, prg_raw_high;
    logic             prg_fix_bit3;

    function automatic logic [PRG_BANK_W-1:0] fold_prg(
        input logic [REG_W-1:0] raw,
        input logic             fix_bit3,
        input logic             prg_bit3
    );
        if (fix_bit3) begin
            return {prg_bit3, raw[2:0]};
        end
        return raw[PRG_BANK_W-1:0];
    endfunction

    always_comb begin
        if (i_regs.control[3]) begin
            if (i_regs.control[2]) begin
                // Low window switchable, high window pinned to the last bank.
                prg_raw_low  = i_regs.prg;
                prg_raw_high = i_regs.prg | 5'h0F;
            end else begin
                prg_raw_low  = '0;
                prg_raw_high = i_regs.prg & 5'h0F;
            end
        end else begin
            prg_raw_low  = {i_regs.prg[4:1], 1'b0};
            prg_raw_high = {i_regs.prg[4:1], 1'b1};
        end
    end

    assign prg_fix_bit3 = i_regs.prg[4] && i_regs.variant_a;

    always_comb begin
        o_result.prg_bank_low  = fold_prg(prg_raw_low, prg_fix_bit3, i_regs.prg[3]);
        o_result.prg_bank_high = fold_prg(prg_raw_high, prg_fix_bit3, i_regs.prg[3]);
        if (i_regs.control[4]) begin
            o_result.chr_bank_low  = i_regs.chr_first;
            o_result.chr_bank_high = i_regs.chr_second;
        end else begin
            o_result.chr_bank_low  = {i_regs.chr_first[4:1], 1'b0};
            o_result.chr_bank_high = {i_regs.chr_first[4:1], 1'b1};
        end
        o_result.mirroring     = i_regs.control[MIRROR_W-1:0];
        o_result.wram_enabled  = i_regs.variant_a || !i_regs.prg[4];
        o_result.open_bus_data = i_address[ADDR_W-1:ADDR_W-DATA_W];
    end

endmodule

// ----- sv/slbm_skid.sv -----
module slbm_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  slbm_pkg::t_result i_result,
    slbm_out_if.source        o_out
);
    import slbm_pkg::*;

    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    out_fire, take, load_out;

    assign o_ready  = !r_skid_valid;
    assign out_fire = r_out_valid && o_out.ready;
    assign take     = i_valid && !r_skid_valid;
    assign load_out = !r_out_valid || out_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            // A parked beat moves up; otherwise the output empties.
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (load_out) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end else if (out_fire && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.prg_bank_low  = r_out.prg_bank_low;
    assign o_out.prg_bank_high = r_out.prg_bank_high;
    assign o_out.chr_bank_low  = r_out.chr_bank_low;
    assign o_out.chr_bank_high = r_out.chr_bank_high;
    assign o_out.mirroring     = r_out.mirroring;
    assign o_out.wram_enabled  = r_out.wram_enabled;
    assign o_out.open_bus_data = r_out.open_bus_data;

endmodule

// ----- sv/serial_loaded_bank_mapper_core.sv -----
// Channel   Dir  Modport  Payload
// i_in      in   sink     opcode, address, write_data
// o_out     out  source   prg/chr banks, mirroring, wram_enabled, open_bus_data
// i_cfg     in   sink     chip_is_variant_a
//
// One beat in, one beat out; a beat can be accepted on every cycle while the skid entry is empty.
// The result is registered in the output buffer before it appears on o_out.
// The mapper registers update on the accepting edge and the result decode runs
// off their next values; the result then passes through a two-entry output buffer.
// Reset is synchronous and active low; the configuration port is always ready.
// With the output stalled, one more input beat is parked before i_in.ready drops.
module serial_loaded_bank_mapper_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slbm_in_if.sink    i_in,
    slbm_out_if.source o_out,
    slbm_cfg_if.sink   i_cfg
);
    import slbm_pkg::*;

    logic       in_ready;
    logic       in_accept;
    t_bank_regs regs_next;
    t_result    result;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign in_accept   = i_in.valid && in_ready;

    slbm_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_opcode        (t_opcode'(i_in.opcode)),
        .i_address       (i_in.address),
        .i_write_data    (i_in.write_data),
        .i_cfg_write     (i_cfg.valid),
        .i_cfg_variant_a (i_cfg.chip_is_variant_a),
        .o_regs_next     (regs_next)
    );

    slbm_decode u_decode (
        .i_regs    (regs_next),
        .i_address (i_in.address),
        .o_result  (result)
    );

    slbm_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (in_ready),
        .i_result (result),
        .o_out    (o_out)
    );

endmodule

// ----- sim/tb_serial_loaded_bank_mapper_core.sv -----
`timescale 1ns / 100ps

module tb_serial_loaded_bank_mapper_core;
    import slbm_pkg::*;

    localparam int IDLE_PCT      = 11;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;

    logic i_clk;
    logic i_rst_n;

    slbm_in_if  in_if ();
    slbm_out_if out_if ();
    slbm_cfg_if cfg_if ();

    serial_loaded_bank_mapper_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Mirror of the mapper registers, updated on every accepted beat.
    logic [REG_W-1:0]   ctrl_q;
    logic [REG_W-1:0]   chr_first_q;
    logic [REG_W-1:0]   chr_second_q;
    logic [REG_W-1:0]   prg_q;
    logic [REG_W-1:0]   shifter_q;
    logic [COUNT_W-1:0] bit_count_q;
    logic [GUARD_W-1:0] guard_q;
    logic               variant_a_q;

    t_result pending_mappings[$];
    int      mismatch_count;
    int      items_sent;
    int      cycle_count;
    int      hold_tokens;
    bit      no_idle;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [PRG_BANK_W-1:0] prg_bank_of(logic half);
        logic [REG_W-1:0] bank;
        if (ctrl_q[3]) begin
            if (ctrl_q[2]) begin
                bank = half ? (prg_q | 5'h0F) : prg_q;
            end else begin
                bank = half ? (prg_q & 5'h0F) : 5'd0;
            end
        end else begin
            bank = {prg_q[4:1], half};
        end
        // The A variant passes bank bit 3 straight through when bit 4 is set.
        if (prg_q[4] && variant_a_q)
            return {prg_q[3], bank[2:0]};
        return bank[3:0];
    endfunction

    function automatic logic [CHR_BANK_W-1:0] chr_bank_of(logic half);
        if (ctrl_q[4])
            return half ? chr_second_q : chr_first_q;
        return {chr_first_q[4:1], half};
    endfunction

    function automatic t_result apply_bus_access(t_opcode op, logic [ADDR_W-1:0] addr,
                                                 logic [DATA_W-1:0] data);
        t_result r;
        case (op)
            OP_TICK: begin
                if (guard_q != '0)
                    guard_q = guard_q - 1'b1;
            end
            OP_PORT_WRITE: begin
                if (data[RESET_BIT]) begin
                    ctrl_q      = ctrl_q | CONTROL_FORCE;
                    shifter_q   = '0;
                    bit_count_q = '0;
                end else if (guard_q == '0) begin
                    shifter_q   = shifter_q | (REG_W'(data[0]) << bit_count_q);
                    bit_count_q = bit_count_q + 1'b1;
                    if (bit_count_q == BITS_PER_REG) begin
                        case (t_reg_sel'(addr[14:13]))
                            SEL_CONTROL:    ctrl_q       = shifter_q;
                            SEL_CHR_FIRST:  chr_first_q  = shifter_q;
                            SEL_CHR_SECOND: chr_second_q = shifter_q;
                            default:        prg_q        = shifter_q;
                        endcase
                        shifter_q   = '0;
                        bit_count_q = '0;
                    end
                end
                guard_q = GUARD_RELOAD;
            end
            default: ;
        endcase
        r.prg_bank_low  = prg_bank_of(1'b0);
        r.prg_bank_high = prg_bank_of(1'b1);
        r.chr_bank_low  = chr_bank_of(1'b0);
        r.chr_bank_high = chr_bank_of(1'b1);
        r.mirroring     = ctrl_q[1:0];
        r.wram_enabled  = variant_a_q || !prg_q[4];
        r.open_bus_data = addr[15:8];
        return r;
    endfunction

    function automatic void report_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    function automatic void check_field(string name, logic [7:0] exp, logic [7:0] act);
        if (act !== exp)
            report_failure($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act));
    endfunction

    // Predicts on the input beat and checks on the output beat, both sampled at the edge.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            ctrl_q       = CONTROL_RESET;
            chr_first_q  = '0;
            chr_second_q = '0;
            prg_q        = '0;
            shifter_q    = '0;
            bit_count_q  = '0;
            guard_q      = '0;
            variant_a_q  = 1'b0;
            pending_mappings.delete();
        end else begin
            if (cfg_if.valid && cfg_if.ready)
                variant_a_q = cfg_if.chip_is_variant_a;
            if (in_if.valid && in_if.ready)
                pending_mappings.push_back(apply_bus_access(t_opcode'(in_if.opcode),
                                                            in_if.address, in_if.write_data));
            if (out_if.valid && out_if.ready) begin
                if (pending_mappings.size() == 0) begin
                    report_failure("result beat with no expected mapping");
                end else begin
                    want = pending_mappings.pop_front();
                    check_field("prg_bank_low", 8'(want.prg_bank_low),
                                8'(out_if.prg_bank_low));
                    check_field("prg_bank_high", 8'(want.prg_bank_high),
                                8'(out_if.prg_bank_high));
                    check_field("chr_bank_low", 8'(want.chr_bank_low),
                                8'(out_if.chr_bank_low));
                    check_field("chr_bank_high", 8'(want.chr_bank_high),
                                8'(out_if.chr_bank_high));
                    check_field("mirroring", 8'(want.mirroring), 8'(out_if.mirroring));
                    check_field("wram_enabled", 8'(want.wram_enabled),
                                8'(out_if.wram_enabled));
                    check_field("open_bus_data", want.open_bus_data, out_if.open_bus_data);
                end
            end
        end
    end

    // Result side: random stalls, plus a long hold-off whenever a test asks for one.
    initial begin : result_sink
        int hold_left;
        int tokens_seen;
        hold_left   = 0;
        tokens_seen = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_tokens != tokens_seen) begin
                tokens_seen = hold_tokens;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (no_idle) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic send_access(t_opcode op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.opcode     <= op;
        in_if.address    <= addr;
        in_if.write_data <= data;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
    endtask

    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_mappings.size() != 0);
    endtask

    task automatic apply_variant(logic variant_a);
        wait_for_results();
        cfg_if.valid             <= 1'b1;
        cfg_if.chip_is_variant_a <= variant_a;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // At least two ticks after each port write so that the next bit is taken.
    // Work RAM accesses may fall in between; they leave the guard alone.
    task automatic settle_guard();
        int ticks;
        ticks = $urandom_range(3, 2);
        repeat (ticks) begin
            if ($urandom_range(4) == 0)
                send_access($urandom_range(1) ? OP_WRAM_READ : OP_WRAM_WRITE,
                            16'($urandom), 8'($urandom));
            send_access(OP_TICK, 16'($urandom), 8'($urandom));
        end
    endtask

    task automatic run_traffic(int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(99) < 80) begin
                if ($urandom_range(3) == 0) begin
                    send_access(OP_PORT_WRITE, 16'($urandom), 8'h80 | 8'($urandom));
                    settle_guard();
                end
                repeat (BITS_PER_REG) begin
                    send_access(OP_PORT_WRITE, 16'($urandom), {1'b0, 7'($urandom)});
                    settle_guard();
                end
            end else begin
                send_access(t_opcode'($urandom_range(3)), 16'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic test_directed_cases();
        apply_variant(1'b0);
        send_access(OP_TICK, 16'h0000, 8'h00);
        send_access(OP_WRAM_READ, 16'h6000, 8'h00);
        send_access(OP_WRAM_WRITE, 16'h7FFF, 8'hFF);
        send_access(OP_PORT_WRITE, 16'h8000, 8'h80);
        // Both of these land inside the guard window and must be dropped.
        send_access(OP_PORT_WRITE, 16'hFFFF, 8'h01);
        send_access(OP_TICK, 16'hFFFF, 8'hFF);
        send_access(OP_PORT_WRITE, 16'hFFFF, 8'h01);
        repeat (2) send_access(OP_TICK, 16'h0000, 8'h00);
        // Load the program register with all ones; the unused data bits are set too.
        repeat (BITS_PER_REG) begin
            send_access(OP_PORT_WRITE, 16'hE000, 8'h7F);
            repeat (2) send_access(OP_TICK, 16'h1234, 8'h00);
        end
        send_access(OP_WRAM_READ, 16'hFFFF, 8'h00);
        send_access(OP_PORT_WRITE, 16'h0000, 8'hFF);
    endtask

    task automatic test_random_traffic(logic variant_a, int count);
        apply_variant(variant_a);
        run_traffic(count);
    endtask

    task automatic test_backpressure(logic variant_a, int count);
        apply_variant(variant_a);
        hold_tokens++;
        run_traffic(count);
    endtask

    task automatic test_back_to_back(logic variant_a, int count);
        apply_variant(variant_a);
        no_idle = 1'b1;
        run_traffic(count);
        no_idle = 1'b0;
    endtask

    initial begin
        mismatch_count = 0;
        items_sent     = 0;
        cycle_count    = 0;
        hold_tokens    = 0;
        no_idle        = 1'b0;
        i_rst_n                  <= 1'b0;
        in_if.valid              <= 1'b0;
        in_if.opcode             <= OP_TICK;
        in_if.address            <= '0;
        in_if.write_data         <= '0;
        cfg_if.valid             <= 1'b0;
        cfg_if.chip_is_variant_a <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic(1'b0, 300);
        test_backpressure(1'b1, 300);
        test_back_to_back(1'b0, 250);
        test_random_traffic(1'b1, 250);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
